// ----- hdl/xte_pkg.sv -----
// shared types, constants and sequence tables for the xml text escaper
package xte_pkg;

  localparam logic [7:0] CTRL_LIMIT = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LT      = 8'h3c;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_L       = 8'h6c;
  localparam logic [7:0] CH_G       = 8'h67;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_M       = 8'h6d;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] GLYPH_HI_0 = 8'h32;
  localparam logic [7:0] GLYPH_HI_1 = 8'h34;
  localparam logic [7:0] HEX_DIGIT0 = 8'h30;
  localparam logic [7:0] HEX_ALPHA0 = 8'h57;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_CTRL,
    KIND_LT,
    KIND_GT,
    KIND_AMP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    logic empty;
    tok_t head;
  } q_stat_t;

  function automatic logic [7:0] hex_lc(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      return wide + HEX_DIGIT0;
    end else begin
      return wide + HEX_ALPHA0;
    end
  endfunction

  // index of the final byte of each sequence
  function automatic logic [2:0] seq_last(input kind_t kind);
    logic [2:0] n;
    unique case (kind)
      KIND_PLAIN: n = 3'd0;
      KIND_CTRL:  n = 3'd7;
      KIND_LT:    n = 3'd3;
      KIND_GT:    n = 3'd3;
      KIND_AMP:   n = 3'd4;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] seq_byte(input tok_t tok, input logic [2:0] idx);
    logic [7:0] b;
    b = tok.data;
    unique case (tok.kind)
      KIND_PLAIN: b = tok.data;
      KIND_CTRL: begin
        unique case (idx)
          3'd0: b = CH_AMP;
          3'd1: b = CH_HASH;
          3'd2: b = CH_X;
          3'd3: b = GLYPH_HI_0;
          3'd4: b = GLYPH_HI_1;
          3'd5: b = hex_lc(tok.data[7:4]);
          3'd6: b = hex_lc(tok.data[3:0]);
          3'd7: b = CH_SEMI;
          default: b = CH_SEMI;
        endcase
      end
      KIND_LT, KIND_GT: begin
        unique case (idx)
          3'd0:    b = CH_AMP;
          3'd1:    b = (tok.kind == KIND_LT) ? CH_L : CH_G;
          3'd2:    b = CH_T;
          default: b = CH_SEMI;
        endcase
      end
      KIND_AMP: begin
        unique case (idx)
          3'd0:    b = CH_AMP;
          3'd1:    b = CH_A;
          3'd2:    b = CH_M;
          3'd3:    b = CH_P;
          default: b = CH_SEMI;
        endcase
      end
      default: b = tok.data;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/xml_text_escaper.sv -----
// top level of the xml text escaper
//
//   channel  dir  ports                      payload
//   in       in   in_tvalid/tready/tdata     tdata[7:0] in_byte
//   out      out  out_tvalid/tready/tdata    tdata[7:0] out_byte, tlast = last
//
// a plain byte yields one output word; an escaped byte occupies the expander for
// 4, 5 or 8 output words, one output word per cycle from the sequence counter while out_tready does not stall it
// a four-entry token queue lets input words keep arriving during an expansion
// an accepted input word passes through the token queue and then the output register
// synchronous active-low reset empties the queue and the output register
module xml_text_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import xte_pkg::*;

  logic    q_full;
  logic    q_push;
  tok_t    q_tok;
  logic    q_pop;
  q_stat_t q_stat;

  xte_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (q_tok)
  );

  xte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (q_tok),
    .full     (q_full),
    .pop      (q_pop),
    .stat     (q_stat)
  );

  xte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (q_stat),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- hdl/xte_front.sv -----
// input side: accepts text words and classifies each into a token
module xte_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          q_full,
  output logic          q_push,
  output xte_pkg::tok_t q_tok
);
  import xte_pkg::*;

  logic is_ctrl;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  assign is_ctrl = (in_tdata < CTRL_LIMIT) && (in_tdata != CH_LF)
                   && (in_tdata != CH_TAB) && (in_tdata != CH_CR);

  always_comb begin
    q_tok.data = in_tdata;
    priority if (is_ctrl) begin
      q_tok.kind = KIND_CTRL;
    end else if (in_tdata == CH_LT) begin
      q_tok.kind = KIND_LT;
    end else if (in_tdata == CH_GT) begin
      q_tok.kind = KIND_GT;
    end else if (in_tdata == CH_AMP) begin
      q_tok.kind = KIND_AMP;
    end else begin
      q_tok.kind = KIND_PLAIN;
    end
  end

endmodule

// ----- hdl/xte_queue.sv -----
// short token queue between the classifier and the expander
module xte_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xte_pkg::tok_t    push_tok,
  output logic             full,
  input  logic             pop,
  output xte_pkg::q_stat_t stat
);
  import xte_pkg::*;

  tok_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.head  = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ----- hdl/xte_back.sv -----
// output side: expands each token into its byte sequence
module xte_back (
  input  logic             clk,
  input  logic             rst_n,
  input  xte_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);
  import xte_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic       slot_free, emit, at_end;

  assign slot_free = !valid_r || out_tready;
  assign emit      = slot_free && !stat.empty;
  assign at_end    = (idx_r == seq_last(stat.head.kind));
  assign pop       = emit && at_end;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    if (slot_free) begin
      valid_nxt = !stat.empty;
    end
    if (emit) begin
      data_nxt = seq_byte(stat.head, idx_r);
      last_nxt = at_end;
      idx_nxt  = at_end ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// ----- test/tb_xml_text_escaper.sv -----
// self-checking testbench for the xml text escaper, with scoreboard and random idling
`timescale 1ns / 100ps

import xte_pkg::*;

typedef struct packed {
  logic [7:0] glyph;
  logic       last;
} escaped_word_t;

class xml_escape_board;
  escaped_word_t pending_words[$];
  int            failures;
  string         hex_digits;

  function new();
    pending_words = {};
    failures = 0;
    hex_digits = "0123456789abcdef";
  endfunction

  // expands one text byte into the escaped words it should produce
  function void note_text_byte(logic [7:0] text);
    logic [7:0]    chars[$];
    escaped_word_t w;
    chars = {};
    if (text < CTRL_LIMIT && text != CH_TAB && text != CH_LF && text != CH_CR) begin
      chars.push_back(CH_AMP);
      chars.push_back(CH_HASH);
      chars.push_back(CH_X);
      chars.push_back(GLYPH_HI_0);
      chars.push_back(GLYPH_HI_1);
      chars.push_back(hex_digits[text[7:4]]);
      chars.push_back(hex_digits[text[3:0]]);
      chars.push_back(CH_SEMI);
    end else if (text == CH_LT || text == CH_GT) begin
      chars.push_back(CH_AMP);
      chars.push_back((text == CH_LT) ? CH_L : CH_G);
      chars.push_back(CH_T);
      chars.push_back(CH_SEMI);
    end else if (text == CH_AMP) begin
      chars.push_back(CH_AMP);
      chars.push_back(CH_A);
      chars.push_back(CH_M);
      chars.push_back(CH_P);
      chars.push_back(CH_SEMI);
    end else begin
      chars.push_back(text);
    end
    foreach (chars[k]) begin
      w.glyph = chars[k];
      w.last  = (k == chars.size() - 1);
      pending_words.push_back(w);
    end
  endfunction

  function void check_escaped_word(logic [7:0] glyph, logic last);
    escaped_word_t want;
    if (pending_words.size() == 0) begin
      failures++;
      if (failures <= 10) begin
        $display("unexpected output word: byte %h last %b", glyph, last);
      end
    end else begin
      want = pending_words.pop_front();
      if (want.glyph !== glyph || want.last !== last) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: byte exp %h got %h, last exp %b got %b",
                   want.glyph, glyph, want.last, last);
        end
      end
    end
  endfunction

  function int outstanding();
    return pending_words.size();
  endfunction
endclass

module tb_xml_text_escaper;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 310;
  localparam int CALM_WORDS   = 100;
  localparam int DRAIN_CYCLES = 16;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  xml_escape_board board;
  bit              calm;
  int              idle_cycles;
  int              stall_left;

  logic [7:0] corner_bytes [22] = '{
    8'h00, 8'h01, 8'h1f, 8'h0b, 8'h0c, 8'h0e, 8'h1a, 8'h10,
    CH_TAB, CH_LF, CH_CR, 8'h20, CH_LT, CH_GT, CH_AMP, 8'h41,
    8'h7f, 8'h80, 8'hff, 8'haa, 8'h55, CH_AMP
  };

  xml_text_escaper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (calm || roll < 12) begin
      return 0;
    end else if (roll < 18) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = 8'($urandom_range(0, 255));
      4, 5:       b = 8'($urandom_range(0, 31));
      6: begin
        case ($urandom_range(0, 2))
          0:       b = CH_LT;
          1:       b = CH_GT;
          default: b = CH_AMP;
        endcase
      end
      7: begin
        case ($urandom_range(0, 2))
          0:       b = CH_TAB;
          1:       b = CH_LF;
          default: b = CH_CR;
        endcase
      end
      8:       b = 8'($urandom_range(128, 255));
      default: b = 8'($urandom_range(32, 126));
    endcase
    return b;
  endfunction

  task automatic send_text_byte(input logic [7:0] text);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= text;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_text_byte(text);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: check on handshake, then decide whether to stall
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        board.check_escaped_word(out_tdata, out_tlast);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    board      = new();
    calm       = 1'b0;
    stall_left = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    out_tready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_bytes[i]) begin
      send_text_byte(corner_bytes[i]);
    end

    // back-to-back stretch first, then idling on both sides
    calm = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == CALM_WORDS) begin
        calm = 1'b0;
      end
      send_text_byte(pick_text_byte());
    end
    in_tvalid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/xte_pkg.sv
hdl/xte_front.sv
hdl/xte_queue.sv
hdl/xte_back.sv
hdl/xml_text_escaper.sv
test/tb_xml_text_escaper.sv
